/* sv/cmsv_pkg.sv */
// Shared types and constants for the cross marker shape validator.
// No dependencies; every other file of the block imports this package.
package cmsv_pkg;

  // Default coordinate width and number of coordinates in one candidate
  localparam int COORD_BITS_DEF = 12;
  localparam int NUM_COORD      = 10;
  localparam int NUM_POINTS     = 5;

  // Lane pipeline depth; one output register follows in the merge stage
  localparam int PIPE_LAT = 6;
  localparam int NUM_STG  = PIPE_LAT + 1;

  // Configuration port
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STRONG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_FOLLOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELONGATION   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BALANCE      = 2'd3;

  localparam logic [CFG_W-1:0] ANGLE_STRONG_RST = 7'd70;
  localparam logic [CFG_W-1:0] ANGLE_FOLLOW_RST = 7'd30;
  localparam logic [CFG_W-1:0] ELONGATION_RST   = 7'd30;
  localparam logic [CFG_W-1:0] BALANCE_RST      = 7'd20;

  // Percent scale and its square (cosine test works on squared values)
  localparam int PCT_SCALE = 100;
  localparam int COS_SCALE = 10000;

  // Cosine lanes: strong and follow-up test for each of the two corners
  localparam int NUM_COS_LANES = 4;
  localparam int LANE_STRONG0  = 0;
  localparam int LANE_FOLLOW0  = 1;
  localparam int LANE_STRONG1  = 2;
  localparam int LANE_FOLLOW1  = 3;

  // Result beat
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [2:0] {
    REASON_NONE     = 3'd0,
    REASON_ANGLE    = 3'd1,
    REASON_ZERO_ARM = 3'd2,
    REASON_ELONG    = 3'd3,
    REASON_IMBAL    = 3'd4
  } reason_t;

  // Verdicts of the arm lane, handed to the merge stage
  typedef struct packed {
    logic zero_arm;
    logic elong;
    logic imbal;
  } arm_flags_t;

endpackage

/* sv/cmsv_cos_lane.sv */
// One cosine lane: tests whether the cosine at point c between the vectors
// to a and b exceeds thr/100, in six stages. Depends on cmsv_pkg.
module cmsv_cos_lane #(
  parameter int COORD_BITS = cmsv_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic [cmsv_pkg::PIPE_LAT-1:0] en,
  input  logic [COORD_BITS-1:0]        ax,
  input  logic [COORD_BITS-1:0]        ay,
  input  logic [COORD_BITS-1:0]        bx,
  input  logic [COORD_BITS-1:0]        by,
  input  logic [COORD_BITS-1:0]        cx,
  input  logic [COORD_BITS-1:0]        cy,
  input  logic [cmsv_pkg::CFG_W-1:0]   thr,
  output logic                         hit
);
  import cmsv_pkg::*;

  localparam int DW = COORD_BITS + 1;       // signed difference
  localparam int PW = 2 * DW;               // signed product
  localparam int NW = 2 * COORD_BITS + 1;   // squared norm, positive dot
  localparam int SW = 2 * NW;
  localparam int TW = 2 * CFG_W;
  localparam int XW = SW + TW;

  logic signed [DW-1:0] dx1, dy1, dx2, dy2;
  logic signed [PW-1:0] mxx, myy, sx1, sy1, sx2, sy2;
  logic signed [PW:0]   dot;
  logic [NW-1:0]        n1, n2, du;
  logic [SW-1:0]        dsq, nn;
  logic [TW-1:0]        tt;
  logic                 pos4, pos5;
  logic [XW-1:0]        lhs, rhs;

  assign du = NW'($unsigned(dot));

  always_ff @(posedge clk) begin
    // stage 1: vectors from the corner
    if (en[0]) begin
      dx1 <= $signed({1'b0, ax}) - $signed({1'b0, cx});
      dy1 <= $signed({1'b0, ay}) - $signed({1'b0, cy});
      dx2 <= $signed({1'b0, bx}) - $signed({1'b0, cx});
      dy2 <= $signed({1'b0, by}) - $signed({1'b0, cy});
    end
    // stage 2: component products
    if (en[1]) begin
      mxx <= dx1 * dx2;
      myy <= dy1 * dy2;
      sx1 <= dx1 * dx1;
      sy1 <= dy1 * dy1;
      sx2 <= dx2 * dx2;
      sy2 <= dy2 * dy2;
    end
    // stage 3: dot product and squared norms
    if (en[2]) begin
      dot <= (PW + 1)'(mxx) + (PW + 1)'(myy);
      n1  <= NW'($unsigned(sx1)) + NW'($unsigned(sy1));
      n2  <= NW'($unsigned(sx2)) + NW'($unsigned(sy2));
    end
    // stage 4: squares; a non-positive dot never exceeds a threshold
    if (en[3]) begin
      pos4 <= !dot[PW] && (dot != '0);
      dsq  <= SW'(du) * SW'(du);
      nn   <= SW'(n1) * SW'(n2);
      tt   <= TW'(thr) * TW'(thr);
    end
    // stage 5: (dot*100)^2 against thr^2 * n1 * n2
    if (en[4]) begin
      pos5 <= pos4;
      lhs  <= XW'(dsq) * XW'(COS_SCALE);
      rhs  <= XW'(nn) * XW'(tt);
    end
    // stage 6
    if (en[5]) begin
      hit <= pos5 && (lhs > rhs);
    end
  end

endmodule

/* sv/cmsv_arm_lane.sv */
// Arm lane: Manhattan arm lengths, zero-arm, elongation and imbalance
// tests in six stages. Depends on cmsv_pkg.
module cmsv_arm_lane #(
  parameter int COORD_BITS = cmsv_pkg::COORD_BITS_DEF
) (
  input  logic                                            clk,
  input  logic [cmsv_pkg::PIPE_LAT-1:0]                    en,
  input  logic [cmsv_pkg::NUM_POINTS-1:0][COORD_BITS-1:0] px,
  input  logic [cmsv_pkg::NUM_POINTS-1:0][COORD_BITS-1:0] py,
  input  logic [cmsv_pkg::CFG_W-1:0]                      elong_pct,
  input  logic [cmsv_pkg::CFG_W-1:0]                      bal_pct,
  output cmsv_pkg::arm_flags_t                            flags
);
  import cmsv_pkg::*;

  localparam int AW   = COORD_BITS + 1;
  localparam int EW   = AW + 8;
  localparam int MW   = 2 * AW;
  localparam int DSW  = 2 * AW + 1;
  localparam int TW4  = 4 * AW + 1;
  localparam int SUMW = 4 * AW + 2;
  localparam int LW   = 4 * AW + 9;

  function automatic logic [COORD_BITS-1:0] absd(input logic [COORD_BITS-1:0] a,
                                                 input logic [COORD_BITS-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // arms in test order: bottom, top, left, right
  logic [3:0][AW-1:0] arm_c, arm;
  logic [3:0][EW-1:0] m;
  logic [AW-1:0]      d1, d2;
  logic [AW:0]        s1, s2;
  logic [MW-1:0]      p01, p23, p01_3, p23_3;
  logic [DSW-1:0]     ds1, ds2;
  logic [TW4-1:0]     t1, t2;
  logic [2*MW-1:0]    pp;
  logic [SUMW-1:0]    tsum;
  logic [LW-1:0]      rhs;
  logic               zero2, zero3, zero4, zero5;
  logic               elong3, elong4, elong5;

  always_comb begin
    arm_c[0] = AW'(absd(px[0], px[2])) + AW'(absd(py[0], py[2]));
    arm_c[1] = AW'(absd(px[3], px[2])) + AW'(absd(py[3], py[2]));
    arm_c[2] = AW'(absd(px[1], px[2])) + AW'(absd(py[1], py[2]));
    arm_c[3] = AW'(absd(px[4], px[2])) + AW'(absd(py[4], py[2]));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      arm <= arm_c;
    end
    // stage 2: elongation products, differences, sums, pair products
    if (en[1]) begin
      zero2 <= (arm[0] == '0) || (arm[1] == '0) || (arm[2] == '0) || (arm[3] == '0);
      m[0]  <= EW'(arm[0]) * EW'(PCT_SCALE);
      m[1]  <= EW'(arm[1]) * (EW'(PCT_SCALE) + EW'(elong_pct));
      m[2]  <= EW'(arm[2]) * EW'(PCT_SCALE);
      m[3]  <= EW'(arm[3]) * (EW'(PCT_SCALE) + EW'(elong_pct));
      d1    <= (arm[0] > arm[1]) ? arm[0] - arm[1] : arm[1] - arm[0];
      d2    <= (arm[2] > arm[3]) ? arm[2] - arm[3] : arm[3] - arm[2];
      s1    <= (AW + 1)'(arm[0]) + (AW + 1)'(arm[1]);
      s2    <= (AW + 1)'(arm[2]) + (AW + 1)'(arm[3]);
      p01   <= MW'(arm[0]) * MW'(arm[1]);
      p23   <= MW'(arm[2]) * MW'(arm[3]);
    end
    if (en[2]) begin
      zero3  <= zero2;
      elong3 <= (m[0] > m[1]) || (m[2] > m[3]);
      ds1    <= DSW'(d1) * DSW'(s1);
      ds2    <= DSW'(d2) * DSW'(s2);
      p01_3  <= p01;
      p23_3  <= p23;
    end
    if (en[3]) begin
      zero4  <= zero3;
      elong4 <= elong3;
      t1     <= TW4'(ds1) * TW4'(p23_3);
      t2     <= TW4'(ds2) * TW4'(p01_3);
      pp     <= (2 * MW)'(p01_3) * (2 * MW)'(p23_3);
    end
    // stage 5: imbalance sum against 4 * balance * a0*a1*a2*a3
    if (en[4]) begin
      zero5  <= zero4;
      elong5 <= elong4;
      tsum   <= SUMW'(t1) + SUMW'(t2);
      rhs    <= LW'(pp) * LW'({bal_pct, 2'b00});
    end
    if (en[5]) begin
      flags.zero_arm <= zero5;
      flags.elong    <= elong5;
      flags.imbal    <= (LW'(tsum) * LW'(PCT_SCALE)) > rhs;
    end
  end

endmodule

/* sv/cmsv_merge.sv */
// Merge stage: combines the lane verdicts by test priority into the
// registered result. Depends on cmsv_pkg.
module cmsv_merge (
  input  logic                               clk,
  input  logic                               en,
  input  logic [cmsv_pkg::NUM_COS_LANES-1:0] cos_hit,
  input  cmsv_pkg::arm_flags_t               flags,
  output logic                               accepted,
  output cmsv_pkg::reason_t                  reason
);
  import cmsv_pkg::*;

  reason_t reason_next;

  always_comb begin
    priority if ((cos_hit[LANE_STRONG0] && !cos_hit[LANE_FOLLOW0]) ||
                 (cos_hit[LANE_STRONG1] && !cos_hit[LANE_FOLLOW1])) begin
      reason_next = REASON_ANGLE;
    end else if (flags.zero_arm) begin
      reason_next = REASON_ZERO_ARM;
    end else if (flags.elong) begin
      reason_next = REASON_ELONG;
    end else if (flags.imbal) begin
      reason_next = REASON_IMBAL;
    end else begin
      reason_next = REASON_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      reason   <= reason_next;
      accepted <= (reason_next == REASON_NONE);
    end
  end

endmodule

/* sv/cross_marker_shape_validator.sv */
// Top level of the cross marker shape validator: stream ports, config
// registers, pipeline valids. Depends on cmsv_pkg and the cmsv_* lanes.
//
// Usage
//   s_axis: one beat per candidate, five points (bottom, left, centre, top,
//     right tip) as ten unsigned coordinates.
//   m_axis: one beat per candidate: accepted flag and reject reason
//     (none, angle, zero arm, elongation, imbalance; first failing test).
//   cfg: write enable, index, data; thresholds in percent. Write only
//     while no candidate is in flight.
// Depth: 7 register stages; a result shows on m_axis from the last one,
//   which the merge stage drives.
// Throughput: one candidate per cycle while m_axis does not stall. Four
//   cosine lanes and one arm lane run side by side, each pipelined 6
//   deep, and the merge stage holds the output register.
// Stall: every stage advances when the one after it is empty or moving,
//   so bubbles collapse and input is still taken while a result waits;
//   once all 7 stages hold beats, s_axis_tready drops until m_axis moves.
// Reset: rst (synchronous) empties the pipeline and sets the thresholds
//   to 70, 30, 30 and 20 percent.
module cross_marker_shape_validator #(
  parameter int COORD_BITS = cmsv_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y (low first),
  // COORD_BITS each, zero padded to bytes
  input  logic [((cmsv_pkg::NUM_COORD*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // accepted [0], reject_reason [3:1], zero padding [7:4]
  output logic [cmsv_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_wr_en,
  input  logic [cmsv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cmsv_pkg::CFG_W-1:0]           cfg_data
);
  import cmsv_pkg::*;

  // threshold registers
  logic [CFG_W-1:0] angle_strong_pct, angle_follow_pct, elongation_pct, balance_pct;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_strong_pct <= ANGLE_STRONG_RST;
      angle_follow_pct <= ANGLE_FOLLOW_RST;
      elongation_pct   <= ELONGATION_RST;
      balance_pct      <= BALANCE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ANGLE_STRONG: angle_strong_pct <= cfg_data;
        REG_ANGLE_FOLLOW: angle_follow_pct <= cfg_data;
        REG_ELONGATION:   elongation_pct   <= cfg_data;
        REG_BALANCE:      balance_pct      <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control: stage k loads when empty or when stage k+1 loads
  logic [NUM_STG-1:0] vld, en;

  always_comb begin
    en[NUM_STG-1] = !vld[NUM_STG-1] || m_axis_tready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_axis_tvalid;
      for (int k = 1; k < NUM_STG; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld[NUM_STG-1];

  // unpack the beat
  logic [NUM_POINTS-1:0][COORD_BITS-1:0] px, py;

  always_comb begin
    for (int i = 0; i < NUM_POINTS; i++) begin
      px[i] = s_axis_tdata[(2*i)*COORD_BITS +: COORD_BITS];
      py[i] = s_axis_tdata[(2*i+1)*COORD_BITS +: COORD_BITS];
    end
  end

  // cosine lanes: corner j, strong test at p[j+2] over p[j], p[j+1];
  // follow-up at p[j+3] over p[j+1], p[j+2]
  logic [NUM_COS_LANES-1:0] cos_hit;

  for (genvar l = 0; l < NUM_COS_LANES; l++) begin : g_cos
    localparam int J = l / 2;
    localparam int F = l % 2;
    cmsv_cos_lane #(
      .COORD_BITS(COORD_BITS)
    ) u_lane (
      .clk (clk),
      .en  (en[PIPE_LAT-1:0]),
      .ax  (px[J+F]),
      .ay  (py[J+F]),
      .bx  (px[J+F+1]),
      .by  (py[J+F+1]),
      .cx  (px[J+F+2]),
      .cy  (py[J+F+2]),
      .thr ((F == 1) ? angle_follow_pct : angle_strong_pct),
      .hit (cos_hit[l])
    );
  end

  arm_flags_t arm_flags;

  cmsv_arm_lane #(
    .COORD_BITS(COORD_BITS)
  ) u_arm (
    .clk       (clk),
    .en        (en[PIPE_LAT-1:0]),
    .px        (px),
    .py        (py),
    .elong_pct (elongation_pct),
    .bal_pct   (balance_pct),
    .flags     (arm_flags)
  );

  logic    accepted;
  reason_t reject_reason;

  cmsv_merge u_merge (
    .clk      (clk),
    .en       (en[NUM_STG-1]),
    .cos_hit  (cos_hit),
    .flags    (arm_flags),
    .accepted (accepted),
    .reason   (reject_reason)
  );

  assign m_axis_tdata = {4'b0000, reject_reason, accepted};

endmodule

/* sv/cmsv_checker.sv */
// Port-level checks for the cross marker shape validator, bound to the top.
// Depends on cmsv_pkg and cross_marker_shape_validator.
module cmsv_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [cmsv_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import cmsv_pkg::*;

  // accepted flag and reason code agree
  a_flag_vs_reason: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == REASON_NONE)))
    else $error("accepted flag disagrees with reject reason");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed under stall");

  // an empty or draining output never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input blocked while output side can move");

  // with the sink always ready, a result shows after the pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
      |=> m_axis_tvalid)
    else $error("result missing after pipeline latency");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind cross_marker_shape_validator cmsv_checker u_cmsv_checker (.*);

/* verif/cmsv_verdict_checker.sv */
// Scoreboard for the cross marker shape validator: watches the config port and
// both stream channels, predicts each verdict and compares it on m_axis.
// Depends on cmsv_pkg only.
module cmsv_verdict_checker #(
  parameter int COORD_BITS = cmsv_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic [((cmsv_pkg::NUM_COORD*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic s_axis_tvalid,
  input  logic s_axis_tready,
  input  logic [cmsv_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic cfg_wr_en,
  input  logic [cmsv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cmsv_pkg::CFG_W-1:0] cfg_data,
  output int errors,
  output int pending,
  output logic [4:0][15:0] reason_hits
);
  import cmsv_pkg::*;

  localparam int DATA_W = ((NUM_COORD*COORD_BITS+7)/8)*8;

  // shadow copy of the thresholds
  longint strong_pct = ANGLE_STRONG_RST;
  longint follow_pct = ANGLE_FOLLOW_RST;
  longint elong_pct  = ELONGATION_RST;
  longint bal_pct    = BALANCE_RST;

  reason_t verdict_q[$];
  int err_cnt = 0;
  logic [4:0][15:0] hit_cnt = '0;

  // cos(angle at c between a and b) > t/100, squared and cross-multiplied
  function automatic logic cos_above(input longint ax, ay, bx, by, cx, cy, t);
    longint dx1, dy1, dx2, dy2, dot, n1, n2;
    logic [127:0] num, den;
    dx1 = ax - cx;
    dy1 = ay - cy;
    dx2 = bx - cx;
    dy2 = by - cy;
    dot = dx1 * dx2 + dy1 * dy2;
    if (dot <= 0) return 1'b0;
    n1 = dx1 * dx1 + dy1 * dy1;
    n2 = dx2 * dx2 + dy2 * dy2;
    num = 128'(dot * 100);
    num = num * num;
    den = 128'(t) * 128'(t) * 128'(n1) * 128'(n2);
    return num > den;
  endfunction

  function automatic longint manhattan_arm(input longint ax, ay, cx, cy);
    longint dx, dy;
    dx = ax > cx ? ax - cx : cx - ax;
    dy = ay > cy ? ay - cy : cy - ay;
    return dx + dy;
  endfunction

  function automatic reason_t judge_candidate(input logic [DATA_W-1:0] beat);
    longint xs[5], ys[5];
    longint a0, a1, a2, a3, d1, d2;
    logic [127:0] lhs, rhs;
    for (int i = 0; i < 5; i++) begin
      xs[i] = beat[(2*i)*COORD_BITS +: COORD_BITS];
      ys[i] = beat[(2*i+1)*COORD_BITS +: COORD_BITS];
    end
    for (int j = 0; j < 2; j++) begin
      if (cos_above(xs[j], ys[j], xs[j+1], ys[j+1], xs[j+2], ys[j+2], strong_pct) &&
          !cos_above(xs[j+1], ys[j+1], xs[j+2], ys[j+2], xs[j+3], ys[j+3], follow_pct))
        return REASON_ANGLE;
    end
    a0 = manhattan_arm(xs[0], ys[0], xs[2], ys[2]);
    a1 = manhattan_arm(xs[3], ys[3], xs[2], ys[2]);
    a2 = manhattan_arm(xs[1], ys[1], xs[2], ys[2]);
    a3 = manhattan_arm(xs[4], ys[4], xs[2], ys[2]);
    if (a0 == 0 || a1 == 0 || a2 == 0 || a3 == 0) return REASON_ZERO_ARM;
    if (a0 * 100 > (100 + elong_pct) * a1) return REASON_ELONG;
    if (a2 * 100 > (100 + elong_pct) * a3) return REASON_ELONG;
    d1 = a0 > a1 ? a0 - a1 : a1 - a0;
    d2 = a2 > a3 ? a2 - a3 : a3 - a2;
    lhs = 128'(100 * d1 * (a0 + a1)) * 128'(a2 * a3) +
          128'(100 * d2 * (a2 + a3)) * 128'(a0 * a1);
    rhs = 128'(4 * bal_pct * a0 * a1) * 128'(a2 * a3);
    if (lhs > rhs) return REASON_IMBAL;
    return REASON_NONE;
  endfunction

  always @(posedge clk) begin
    reason_t want;
    logic got_acc;
    logic [2:0] got_reason;
    if (rst) begin
      strong_pct = ANGLE_STRONG_RST;
      follow_pct = ANGLE_FOLLOW_RST;
      elong_pct  = ELONGATION_RST;
      bal_pct    = BALANCE_RST;
      verdict_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ANGLE_STRONG: strong_pct = cfg_data;
          REG_ANGLE_FOLLOW: follow_pct = cfg_data;
          REG_ELONGATION:   elong_pct  = cfg_data;
          REG_BALANCE:      bal_pct    = cfg_data;
          default: ;
        endcase
      end
      // pop before push: a beat taken on this edge cannot answer on it
      if (m_axis_tvalid && m_axis_tready) begin
        got_acc = m_axis_tdata[0];
        got_reason = m_axis_tdata[3:1];
        if (verdict_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result beat accepted=%0d reason=%0d", $time,
                   got_acc, got_reason);
        end else begin
          want = verdict_q.pop_front();
          hit_cnt[want] = 16'(hit_cnt[want] + 16'd1);
          if (got_acc !== (want == REASON_NONE) || got_reason !== want) begin
            err_cnt++;
            $display({"%0t: verdict mismatch: expected accepted=%0d reason=%0d, ",
                      "got accepted=%0d reason=%0d"},
                     $time, want == REASON_NONE, want, got_acc, got_reason);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        verdict_q.insert(verdict_q.size(), judge_candidate(s_axis_tdata));
      end
    end
    errors <= err_cnt;
    pending <= verdict_q.size();
    reason_hits <= hit_cnt;
  end

endmodule

/* verif/cross_marker_shape_validator_tb.sv */
// Testbench top for the cross marker shape validator: clock, reset, stimulus
// and verdict. Depends on cmsv_pkg, the block and cmsv_verdict_checker.
module cross_marker_shape_validator_tb;
  import cmsv_pkg::*;

  localparam int CB             = COORD_BITS_DEF;
  localparam int COORD_MAX      = (1 << CB) - 1;
  localparam int DATA_W         = ((NUM_COORD*CB+7)/8)*8;
  localparam int NUM_PHASES     = 9;
  localparam int RAND_PER_PHASE = 200;
  // watchdog limit on the run length, with ample margin over the slowest legal run
  localparam int CYCLE_LIMIT    = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y (low first)
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // accepted [0], reject_reason [3:1], padding [7:4]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  int errors, pending;
  logic [4:0][15:0] reason_hits;
  int cycles = 0;
  int items_sent = 0;
  int burst_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cross_marker_shape_validator #(.COORD_BITS(CB)) i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cmsv_verdict_checker #(.COORD_BITS(CB)) i_checker (
    .clk(clk),
    .rst(rst),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors),
    .pending(pending),
    .reason_hits(reason_hits)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sink back-pressure. The pattern changes after a run of random length:
  // always ready, coin flip, mostly stalled, or a fixed duty cycle.
  int sink_mode = 0;
  int sink_left = 0;
  int sink_tick = 0;
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode = $urandom_range(0, 3);
      sink_left = $urandom_range(50, 400);
    end else begin
      sink_left--;
    end
    sink_tick++;
    case (sink_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (sink_tick % 7) < 3;
    endcase
  end

  function automatic int clip(input int v);
    return v < 0 ? 0 : (v > COORD_MAX ? COORD_MAX : v);
  endfunction

  // Pack five points (bottom, left, centre, top, right), clipped to range.
  function automatic logic [DATA_W-1:0] pts(input int x0, y0, x1, y1, x2, y2,
                                                 x3, y3, x4, y4);
    logic [DATA_W-1:0] beat;
    beat = '0;
    beat[0*CB +: CB] = CB'(clip(x0));
    beat[1*CB +: CB] = CB'(clip(y0));
    beat[2*CB +: CB] = CB'(clip(x1));
    beat[3*CB +: CB] = CB'(clip(y1));
    beat[4*CB +: CB] = CB'(clip(x2));
    beat[5*CB +: CB] = CB'(clip(y2));
    beat[6*CB +: CB] = CB'(clip(x3));
    beat[7*CB +: CB] = CB'(clip(y3));
    beat[8*CB +: CB] = CB'(clip(x4));
    beat[9*CB +: CB] = CB'(clip(y4));
    return beat;
  endfunction

  // Roughly cross-shaped candidate: jittered arm lengths, small sideways
  // offsets on each tip. Mostly small crosses, now and then a big one.
  function automatic logic [DATA_W-1:0] rand_cross();
    int cx, cy, len, jit, sway, r;
    int arm[4], off[4];
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2000) : $urandom_range(1, 300);
    cx = $urandom_range(0, COORD_MAX);
    cy = $urandom_range(0, COORD_MAX);
    jit = len / 3 + 1;
    sway = len / 4;
    for (int j = 0; j < 4; j++) begin
      r = $urandom_range(0, 2 * jit);
      arm[j] = len + r - jit;
      r = $urandom_range(0, 2 * sway);
      off[j] = r - sway;
      // occasional stub arm to hit the elongation and zero-length paths
      if ($urandom_range(0, 15) == 0) arm[j] = $urandom_range(0, 3);
    end
    return pts(cx + off[0], cy + arm[0], cx - arm[2], cy + off[2], cx, cy,
               cx + off[1], cy - arm[1], cx + arm[3], cy + off[3]);
  endfunction

  // One random candidate: mostly crosses, then noise, degenerate and corner cases.
  function automatic logic [DATA_W-1:0] rand_candidate();
    logic [DATA_W-1:0] beat;
    int pick, k;
    beat = '0;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      beat = rand_cross();
    end else if (pick < 82) begin
      for (int i = 0; i < NUM_COORD; i++) begin
        beat[i*CB +: CB] = CB'($urandom_range(0, COORD_MAX));
      end
    end else if (pick < 92) begin
      // one tip collapsed onto the centre
      beat = rand_cross();
      k = $urandom_range(0, 3);
      if (k >= 2) k++;
      beat[2*k*CB +: 2*CB] = beat[4*CB +: 2*CB];
    end else begin
      for (int i = 0; i < NUM_COORD; i++) begin
        case ($urandom_range(0, 3))
          0: beat[i*CB +: CB] = '0;
          1: beat[i*CB +: CB] = CB'(COORD_MAX);
          2: beat[i*CB +: CB] = CB'($urandom_range(0, 3));
          default: beat[i*CB +: CB] = CB'(COORD_MAX - $urandom_range(0, 3));
        endcase
      end
    end
    return beat;
  endfunction

  // Push one beat. Bursts of random length, random gaps in between; valid
  // stays high across back-to-back beats inside a burst.
  task automatic send_beat(input logic [DATA_W-1:0] beat);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    s_axis_tdata <= beat;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Stop sending and wait for every outstanding verdict. The checker's count
  // is registered, so look at it only from the next edge on.
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Block is idle here: write all four thresholds back to back.
  task automatic set_thresholds(input logic [CFG_W-1:0] strong_th, follow_th, elong_th,
                                bal_th);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_ANGLE_STRONG;
    cfg_data <= strong_th;
    @(posedge clk);
    cfg_index <= REG_ANGLE_FOLLOW;
    cfg_data <= follow_th;
    @(posedge clk);
    cfg_index <= REG_ELONGATION;
    cfg_data <= elong_th;
    @(posedge clk);
    cfg_index <= REG_BALANCE;
    cfg_data <= bal_th;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] th_s, th_f, th_e, th_b;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass at the reset thresholds
    set_thresholds(ANGLE_STRONG_RST, ANGLE_FOLLOW_RST, ELONGATION_RST, BALANCE_RST);
    send_beat(pts(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(pts(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
    // clean cross, then one spanning the whole field
    send_beat(pts(2048, 2148, 1948, 2048, 2048, 2048, 2048, 1948, 2148, 2048));
    send_beat(pts(2048, 4095, 0, 2048, 2048, 2048, 2048, 0, 4095, 2048));
    // tips in the four corners
    send_beat(pts(0, 4095, 0, 0, 2048, 2048, 4095, 0, 4095, 4095));
    // bottom arm too long, left arm too long
    send_beat(pts(2048, 2248, 1948, 2048, 2048, 2048, 2048, 1948, 2148, 2048));
    send_beat(pts(2048, 2148, 1908, 2048, 2048, 2048, 2048, 1948, 2148, 2048));
    // bottom exactly at the elongation bound; mild imbalance below the limit
    send_beat(pts(2048, 2178, 1948, 2048, 2048, 2048, 2048, 1948, 2148, 2048));
    send_beat(pts(2048, 2158, 1948, 2048, 2048, 2048, 2048, 1948, 2148, 2048));
    // zero-length bottom arm, zero-length right arm
    send_beat(pts(2048, 2048, 1948, 2048, 2048, 2048, 2048, 1948, 2148, 2048));
    send_beat(pts(2048, 2148, 1948, 2048, 2048, 2048, 2048, 1948, 2048, 2048));
    // all five points on one line
    send_beat(pts(100, 100, 200, 200, 300, 300, 400, 400, 500, 500));
    // sharp first corner whose follow-up angle is obtuse
    send_beat(pts(2048, 2148, 2050, 2140, 2048, 2048, 2049, 2100, 2148, 2048));
    // straight second corner whose follow-up dot product is negative
    send_beat(pts(2048, 2148, 1948, 2048, 2048, 2048, 1900, 2048, 2000, 2048));
    // top tip on the left tip: zero vector inside a cosine
    send_beat(pts(2048, 2148, 1948, 2048, 2048, 2048, 1948, 2048, 2148, 2048));
    // alternating bit patterns
    send_beat(pts(12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'hAAA, 12'hAAA,
                  12'h555, 12'h555, 12'hFFF, 12'h000));
    // one-pixel cross at the origin and at the far corner
    send_beat(pts(1, 2, 0, 1, 1, 1, 1, 0, 2, 1));
    send_beat(pts(4094, 4095, 4093, 4094, 4094, 4094, 4094, 4093, 4095, 4094));

    // Random phases, one threshold set each, extremes and above-range included
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        wait_all_results();
        case (ph)
          1: begin th_s = 7'd0;   th_f = 7'd0;   th_e = 7'd0;   th_b = 7'd0;   end
          2: begin th_s = 7'd100; th_f = 7'd100; th_e = 7'd100; th_b = 7'd100; end
          3: begin th_s = 7'd127; th_f = 7'd127; th_e = 7'd127; th_b = 7'd127; end
          4: begin th_s = 7'd100; th_f = 7'd0;   th_e = 7'd0;   th_b = 7'd100; end
          5: begin th_s = 7'd0;   th_f = 7'd100; th_e = 7'd100; th_b = 7'd0;   end
          8: begin th_s = 7'd50;  th_f = 7'd50;  th_e = 7'd15;  th_b = 7'd10;  end
          default: begin
            th_s = CFG_W'($urandom_range(0, 127));
            th_f = CFG_W'($urandom_range(0, 127));
            th_e = CFG_W'($urandom_range(0, 127));
            th_b = CFG_W'($urandom_range(0, 127));
          end
        endcase
        set_thresholds(th_s, th_f, th_e, th_b);
      end
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        // let the pipeline run dry once mid-phase
        if (k == RAND_PER_PHASE / 2) wait_all_results();
        send_beat(rand_candidate());
      end
    end

    wait_all_results();
    // a stray late beat would still be caught by the checker
    repeat (NUM_STG + 4) @(posedge clk);

    $display("Sent %0d candidates over %0d threshold settings (0, 100, 127 and random).",
             items_sent, NUM_PHASES);
    $display("Verdicts: %0d accepted, %0d angle, %0d zero arm, %0d elongation, %0d imbalance.",
             reason_hits[REASON_NONE], reason_hits[REASON_ANGLE],
             reason_hits[REASON_ZERO_ARM], reason_hits[REASON_ELONG],
             reason_hits[REASON_IMBAL]);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
